// ===== src/gdfs_pkg.sv =====
package gdfs_pkg;

    // fixed field widths
    localparam int VERT_W        = 6;
    localparam int NEXT_W        = 7;
    localparam int VC_W          = 7;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 7;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 8;
    localparam int DEF_MAX_NODES = 64;

    // input commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_START = 1'b1;

    // traversal orders
    localparam logic MODE_PREORDER  = 1'b0;
    localparam logic MODE_PUSH_MARK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE   = 1'b1;

    typedef struct packed {
        logic [NEXT_W-1:0] next;
        logic [VERT_W-1:0] vertex;
    } stk_entry_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [VERT_W-1:0] addr;
    } adj_ctl_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [VERT_W-1:0] rd_addr;
        logic [VERT_W-1:0] wr_addr;
        stk_entry_t        wdata;
    } stk_ctl_t;

    typedef struct packed {
        logic              valid;
        logic [VERT_W-1:0] vertex;
        logic              last;
    } emit_t;

endpackage

// ===== src/graph_dfs_matrix_traversal.sv =====
// channel  | direction | fields
// ---------+-----------+--------------------------------------------------------
// s_*      | in        | tuser: command; tdata: row, column, edge present
// m_*      | out       | tdata: visited vertex; tlast: final vertex of the walk
// cfg_*    | in        | cfg_index: register index; cfg_data: register value
//
// a matrix write is a row read, then a row write, with s_tready low during the row write
// a start command holds s_tready low until the walk is done; one adjacency bit is
// tested per cycle by the scan unit
// the result register frees the walk from m_tready while it can load; a stall holds the sequencer at emit
// reset clears the matrix through per-row valid bits, so no clearing pass is needed
module graph_dfs_matrix_traversal
    import gdfs_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row_vertex[5:0], column_vertex[11:6], edge_present[12]
    input  logic                  s_tuser,   // command[0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // visited_vertex[5:0]
    output logic                  m_tlast,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [VC_W-1:0] vertex_count_reg;
    logic            order_mode_reg;

    // result register
    logic              out_valid_reg;
    logic [VERT_W-1:0] out_vertex_reg;
    logic              out_last_reg;

    logic emit_ready;
    emit_t emit;

    adj_ctl_t             adj_ctl;
    logic [MAX_NODES-1:0] adj_wdata;
    logic [MAX_NODES-1:0] row_q;
    stk_ctl_t             stk_ctl;
    stk_entry_t           stk_q;

    // registers are to be written only while the block is idle; the block itself does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VC_W'(1);
            order_mode_reg   <= MODE_PREORDER;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data[VC_W-1:0];
                CFG_ORDER_MODE:   order_mode_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // result register loads when empty or being drained
    assign emit_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_vertex_reg <= emit.vertex;
            out_last_reg   <= emit.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_vertex_reg);
    assign m_tlast  = out_last_reg;

    // sequencer with the shared scan unit
    gdfs_seq #(
        .MAX_NODES (MAX_NODES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .command       (s_tuser),
        .row_vertex    (s_tdata[VERT_W-1:0]),
        .column_vertex (s_tdata[2*VERT_W-1:VERT_W]),
        .edge_present  (s_tdata[2*VERT_W]),
        .vertex_count  (vertex_count_reg),
        .order_mode    (order_mode_reg),
        .adj_ctl       (adj_ctl),
        .adj_wdata     (adj_wdata),
        .row_q         (row_q),
        .stk_ctl       (stk_ctl),
        .stk_q         (stk_q),
        .emit          (emit),
        .emit_ready    (emit_ready)
    );

    // adjacency rows, one row per vertex
    gdfs_adj_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_adj_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (adj_ctl),
        .wdata (adj_wdata),
        .row_q (row_q)
    );

    // pending vertex stack
    gdfs_stack_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_stack_mem (
        .clk (clk),
        .ctl (stk_ctl),
        .q   (stk_q)
    );

endmodule

// ===== src/gdfs_adj_mem.sv =====
module gdfs_adj_mem
    import gdfs_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  adj_ctl_t             ctl,
    input  logic [MAX_NODES-1:0] wdata,
    output logic [MAX_NODES-1:0] row_q
);

    localparam int AW = $clog2(MAX_NODES);

    logic [MAX_NODES-1:0] rows_mem [MAX_NODES];
    logic [MAX_NODES-1:0] row_valid_reg;
    logic [MAX_NODES-1:0] q_reg;
    logic                 q_valid_reg;

    // row storage and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            rows_mem[ctl.addr[AW-1:0]] <= wdata;
        end
        if (ctl.rd)
        begin
            q_reg       <= rows_mem[ctl.addr[AW-1:0]];
            q_valid_reg <= row_valid_reg[ctl.addr[AW-1:0]];
        end
    end

    // a row never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (ctl.wr)
        begin
            row_valid_reg[ctl.addr[AW-1:0]] <= 1'b1;
        end
    end

    assign row_q = q_valid_reg ? q_reg : '0;

endmodule

// ===== src/gdfs_stack_mem.sv =====
module gdfs_stack_mem
    import gdfs_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input  logic       clk,
    input  stk_ctl_t   ctl,
    output stk_entry_t q
);

    localparam int AW = $clog2(MAX_NODES);

    stk_entry_t stack_mem [MAX_NODES];
    stk_entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            stack_mem[ctl.wr_addr[AW-1:0]] <= ctl.wdata;
        end
        if (ctl.rd)
        begin
            q_reg <= stack_mem[ctl.rd_addr[AW-1:0]];
        end
    end

    assign q = q_reg;

endmodule

// ===== src/gdfs_seq.sv =====
module gdfs_seq
    import gdfs_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [VERT_W-1:0]    row_vertex,
    input  logic [VERT_W-1:0]    column_vertex,
    input  logic                 edge_present,
    input  logic [VC_W-1:0]      vertex_count,
    input  logic                 order_mode,
    output adj_ctl_t             adj_ctl,
    output logic [MAX_NODES-1:0] adj_wdata,
    input  logic [MAX_NODES-1:0] row_q,
    output stk_ctl_t             stk_ctl,
    input  stk_entry_t           stk_q,
    output emit_t                emit,
    input  logic                 emit_ready
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [VC_W-1:0] MAX_VC = VC_W'(MAX_NODES);
    localparam logic [VERT_W:0] MAX_IDX = (VERT_W + 1)'(MAX_NODES);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_WRITE     = 4'd1;
    localparam logic [3:0] S_OUTER     = 4'd2;
    localparam logic [3:0] S_PRE_VISIT = 4'd3;
    localparam logic [3:0] S_PRE_SCAN  = 4'd4;
    localparam logic [3:0] S_PRE_POP   = 4'd5;
    localparam logic [3:0] S_MP_POP    = 4'd6;
    localparam logic [3:0] S_MP_WAIT   = 4'd7;
    localparam logic [3:0] S_MP_EMIT   = 4'd8;
    localparam logic [3:0] S_MP_SCAN   = 4'd9;

    logic [3:0]           state_reg,    state_next;
    logic [CW-1:0]        n_reg,        n_next;
    logic [CW-1:0]        s_reg,        s_next;
    logic [CW-1:0]        depth_reg,    depth_next;
    logic [CW-1:0]        cur_i_reg,    cur_i_next;
    logic [CW-1:0]        emit_cnt_reg, emit_cnt_next;
    logic [VERT_W-1:0]    cur_v_reg,    cur_v_next;
    logic [VERT_W-1:0]    cand_reg,     cand_next;
    logic [VERT_W-1:0]    col_reg,      col_next;
    logic                 edge_reg,     edge_next;
    logic [MAX_NODES-1:0] visited_reg,  visited_next;

    logic [CW-1:0] n_lim;
    logic [CW-1:0] k_idx;
    logic          in_range;

    assign n_lim    = (vertex_count > MAX_VC) ? CW'(MAX_NODES) : CW'(vertex_count);
    assign k_idx    = cur_i_reg - CW'(1);
    assign in_range = ({1'b0, row_vertex} < MAX_IDX) && ({1'b0, column_vertex} < MAX_IDX);

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        s_next        = s_reg;
        depth_next    = depth_reg;
        cur_i_next    = cur_i_reg;
        emit_cnt_next = emit_cnt_reg;
        cur_v_next    = cur_v_reg;
        cand_next     = cand_reg;
        col_next      = col_reg;
        edge_next     = edge_reg;
        visited_next  = visited_reg;
        in_ready      = 1'b0;
        adj_ctl       = '0;
        adj_wdata     = row_q;
        stk_ctl       = '0;
        emit          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command == CMD_START)
                    begin
                        n_next        = n_lim;
                        s_next        = '0;
                        depth_next    = '0;
                        emit_cnt_next = '0;
                        visited_next  = '0;
                        state_next    = S_OUTER;
                    end
                    else if (in_range)
                    begin
                        // read-modify-write of one matrix row
                        adj_ctl.rd   = 1'b1;
                        adj_ctl.addr = row_vertex;
                        cur_v_next   = row_vertex;
                        col_next     = column_vertex;
                        edge_next    = edge_present;
                        state_next   = S_WRITE;
                    end
                end
            end

            S_WRITE:
            begin
                adj_wdata[col_reg[AW-1:0]] = edge_reg;
                adj_ctl.wr   = 1'b1;
                adj_ctl.addr = cur_v_reg;
                state_next   = S_IDLE;
            end

            S_OUTER:
            begin
                if (s_reg == n_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (visited_reg[s_reg[AW-1:0]])
                begin
                    s_next = s_reg + CW'(1);
                end
                else if (order_mode == MODE_PREORDER)
                begin
                    cand_next  = VERT_W'(s_reg);
                    state_next = S_PRE_VISIT;
                end
                else
                begin
                    visited_next[s_reg[AW-1:0]] = 1'b1;
                    stk_ctl.wr           = 1'b1;
                    stk_ctl.wr_addr      = '0;
                    stk_ctl.wdata.vertex = VERT_W'(s_reg);
                    stk_ctl.wdata.next   = '0;
                    depth_next           = CW'(1);
                    state_next           = S_MP_POP;
                end
            end

            S_PRE_VISIT:
            begin
                if (emit_ready)
                begin
                    emit.valid    = 1'b1;
                    emit.vertex   = cand_reg;
                    emit.last     = (emit_cnt_reg + CW'(1)) == n_reg;
                    emit_cnt_next = emit_cnt_reg + CW'(1);
                    visited_next[cand_reg[AW-1:0]] = 1'b1;
                    stk_ctl.wr           = 1'b1;
                    stk_ctl.wr_addr      = VERT_W'(depth_reg);
                    stk_ctl.wdata.vertex = cand_reg;
                    stk_ctl.wdata.next   = '0;
                    depth_next   = depth_reg + CW'(1);
                    cur_v_next   = cand_reg;
                    cur_i_next   = '0;
                    adj_ctl.rd   = 1'b1;
                    adj_ctl.addr = cand_reg;
                    state_next   = S_PRE_SCAN;
                end
            end

            S_PRE_SCAN:
            begin
                if (cur_i_reg >= n_reg)
                begin
                    depth_next = depth_reg - CW'(1);
                    if (depth_reg == CW'(1))
                    begin
                        state_next = S_OUTER;
                    end
                    else
                    begin
                        stk_ctl.rd      = 1'b1;
                        stk_ctl.rd_addr = VERT_W'(depth_reg - CW'(2));
                        state_next      = S_PRE_POP;
                    end
                end
                else if (row_q[cur_i_reg[AW-1:0]] && !visited_reg[cur_i_reg[AW-1:0]])
                begin
                    // resume point of this vertex, then descend
                    stk_ctl.wr           = 1'b1;
                    stk_ctl.wr_addr      = VERT_W'(depth_reg - CW'(1));
                    stk_ctl.wdata.vertex = cur_v_reg;
                    stk_ctl.wdata.next   = NEXT_W'(cur_i_reg + CW'(1));
                    cand_next            = VERT_W'(cur_i_reg);
                    state_next           = S_PRE_VISIT;
                end
                else
                begin
                    cur_i_next = cur_i_reg + CW'(1);
                end
            end

            S_PRE_POP:
            begin
                cur_v_next   = stk_q.vertex;
                cur_i_next   = CW'(stk_q.next);
                adj_ctl.rd   = 1'b1;
                adj_ctl.addr = stk_q.vertex;
                state_next   = S_PRE_SCAN;
            end

            S_MP_POP:
            begin
                depth_next      = depth_reg - CW'(1);
                stk_ctl.rd      = 1'b1;
                stk_ctl.rd_addr = VERT_W'(depth_reg - CW'(1));
                state_next      = S_MP_WAIT;
            end

            S_MP_WAIT:
            begin
                cur_v_next   = stk_q.vertex;
                adj_ctl.rd   = 1'b1;
                adj_ctl.addr = stk_q.vertex;
                state_next   = S_MP_EMIT;
            end

            S_MP_EMIT:
            begin
                if (emit_ready)
                begin
                    emit.valid    = 1'b1;
                    emit.vertex   = cur_v_reg;
                    emit.last     = (emit_cnt_reg + CW'(1)) == n_reg;
                    emit_cnt_next = emit_cnt_reg + CW'(1);
                    cur_i_next    = n_reg;
                    state_next    = S_MP_SCAN;
                end
            end

            S_MP_SCAN:
            begin
                // neighbors from the highest index down
                if (cur_i_reg == '0)
                begin
                    state_next = (depth_reg == '0) ? S_OUTER : S_MP_POP;
                end
                else
                begin
                    if (row_q[k_idx[AW-1:0]] && !visited_reg[k_idx[AW-1:0]])
                    begin
                        visited_next[k_idx[AW-1:0]] = 1'b1;
                        stk_ctl.wr           = 1'b1;
                        stk_ctl.wr_addr      = VERT_W'(depth_reg);
                        stk_ctl.wdata.vertex = VERT_W'(k_idx);
                        stk_ctl.wdata.next   = '0;
                        depth_next           = depth_reg + CW'(1);
                    end
                    cur_i_next = k_idx;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            n_reg        <= '0;
            s_reg        <= '0;
            depth_reg    <= '0;
            cur_i_reg    <= '0;
            emit_cnt_reg <= '0;
            visited_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            s_reg        <= s_next;
            depth_reg    <= depth_next;
            cur_i_reg    <= cur_i_next;
            emit_cnt_reg <= emit_cnt_next;
            visited_reg  <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_v_reg <= cur_v_next;
        cand_reg  <= cand_next;
        col_reg   <= col_next;
        edge_reg  <= edge_next;
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CW'(MAX_NODES))
        else $error("stack depth above node count");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (depth_reg == '0))
        else $error("stack not empty in idle");

    a_all_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUTER && s_reg == n_reg) |-> (emit_cnt_reg == n_reg))
        else $error("traversal ended with vertices not emitted");

    a_emit_marked: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |=> visited_reg[$past(emit.vertex[AW-1:0])])
        else $error("emitted vertex not marked visited");
`endif

endmodule

// ===== test/graph_dfs_matrix_traversal_tb.sv =====
module graph_dfs_matrix_traversal_tb;
    import gdfs_pkg::*;

    localparam int NODES     = DEF_MAX_NODES;
    localparam int LONG_HOLD = 600;        // receiver hold-off in cycles
    localparam int RUN_LIMIT = 3000000;    // time units before the watchdog fires

    // one input transaction: a matrix entry write or a walk start
    typedef struct packed {
        logic              cmd;
        logic              edge_on;
        logic [VERT_W-1:0] col;
        logic [VERT_W-1:0] row;
    } graph_op_t;

    // one expected result transaction
    typedef struct packed {
        logic [VERT_W-1:0] vertex;
        logic              last;
    } visit_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = CMD_WRITE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_VERTEX_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    graph_dfs_matrix_traversal i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // graph model: matrix, register copies and the walk itself
    // ---------------------------------------------------------------
    logic [NODES-1:0] adj_rows [NODES] = '{default: '0};   // bit c of row r: edge r -> c
    logic [VC_W-1:0]  cfg_count = 7'd1;
    logic             cfg_mode  = MODE_PREORDER;

    logic [NODES-1:0] walk_seen;
    int unsigned      walk_n;
    int unsigned      walk_emitted;
    int unsigned      dfs_vertex [NODES];
    int unsigned      dfs_next [NODES];
    int unsigned      dfs_depth;

    visit_t    visit_q[$];       // vertices still to come out, in walk order
    graph_op_t pending_ops[$];   // transactions not yet offered to the block

    // bookkeeping for the summary
    int mismatches;
    int ops_accepted;
    int walks_started;
    int visits_checked;
    int reg_writes;

    function automatic void record_visit(input int unsigned v);
        visit_t vt;
        vt.vertex = v[VERT_W-1:0];
        vt.last   = (walk_emitted + 1 == walk_n);
        visit_q.push_back(vt);
        walk_emitted++;
    endfunction

    // true preorder: resume each stacked vertex at its next untried neighbor
    function automatic void walk_lowest_first(input int unsigned s);
        int unsigned top;
        int unsigned v;
        int unsigned i;
        bit          found;
        walk_seen[s] = 1'b1;
        record_visit(s);
        dfs_vertex[0] = s;
        dfs_next[0]   = 0;
        dfs_depth     = 1;
        while (dfs_depth > 0)
        begin
            top   = dfs_depth - 1;
            v     = dfs_vertex[top];
            i     = dfs_next[top];
            found = 1'b0;
            while (!found && i < walk_n)
            begin
                if (adj_rows[v][i] && !walk_seen[i])
                    found = 1'b1;
                else
                    i++;
            end
            if (found)
            begin
                dfs_next[top]         = i + 1;
                walk_seen[i]          = 1'b1;
                record_visit(i);
                dfs_vertex[dfs_depth] = i;
                dfs_next[dfs_depth]   = 0;
                dfs_depth++;
            end
            else
                dfs_depth--;
        end
    endfunction

    // mark on push, neighbors pushed from the highest index down
    function automatic void walk_mark_on_push(input int unsigned s);
        int unsigned v;
        int          k;
        walk_seen[s]  = 1'b1;
        dfs_vertex[0] = s;
        dfs_depth     = 1;
        while (dfs_depth > 0)
        begin
            dfs_depth--;
            v = dfs_vertex[dfs_depth];
            record_visit(v);
            for (k = int'(walk_n) - 1; k >= 0; k--)
            begin
                if (adj_rows[v][k] && !walk_seen[k])
                begin
                    walk_seen[k]          = 1'b1;
                    dfs_vertex[dfs_depth] = k;
                    dfs_depth++;
                end
            end
        end
    endfunction

    // apply one accepted transaction; a start queues every visit it causes
    function automatic void apply_graph_op(input graph_op_t op);
        int unsigned s;
        if (op.cmd == CMD_WRITE)
        begin
            if (op.row < NODES && op.col < NODES)
                adj_rows[op.row][op.col] = op.edge_on;
        end
        else
        begin
            // counts above the node limit act as the limit
            walk_n       = (cfg_count > NODES) ? NODES : cfg_count;
            walk_emitted = 0;
            walk_seen    = '0;
            dfs_depth    = 0;
            for (s = 0; s < walk_n; s++)
            begin
                if (!walk_seen[s])
                begin
                    if (cfg_mode == MODE_PUSH_MARK)
                        walk_mark_on_push(s);
                    else
                        walk_lowest_first(s);
                end
            end
        end
    endfunction

    function automatic int draw_gap(input int pace);
        case (pace)
            0:       return 0;
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // monitor: samples every channel at the rising edge
    // ---------------------------------------------------------------
    logic s_xfer = 1'b0;
    logic m_xfer = 1'b0;

    always @(posedge clk)
    begin : monitor
        graph_op_t op;
        visit_t    want;
        s_xfer <= rst_n && s_tvalid && s_tready;
        m_xfer <= rst_n && m_tvalid && m_tready;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            reg_writes++;
            if (cfg_index == CFG_VERTEX_COUNT)
                cfg_count = cfg_data[VC_W-1:0];
            else if (cfg_index == CFG_ORDER_MODE)
                cfg_mode = cfg_data[0];
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            op.cmd     = s_tuser;
            op.row     = s_tdata[VERT_W-1:0];
            op.col     = s_tdata[2*VERT_W-1:VERT_W];
            op.edge_on = s_tdata[2*VERT_W];
            ops_accepted++;
            if (op.cmd == CMD_START)
                walks_started++;
            apply_graph_op(op);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (visit_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual vertex %0d last %0b",
                         $time, m_tdata[VERT_W-1:0], m_tlast);
            end
            else
            begin
                want = visit_q.pop_front();
                visits_checked++;
                if (m_tdata[VERT_W-1:0] !== want.vertex)
                begin
                    mismatches++;
                    $display("%0t: visited vertex mismatch, expected %0d, actual %0d",
                             $time, want.vertex, m_tdata[VERT_W-1:0]);
                end
                if (m_tlast !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last flag mismatch on vertex %0d, expected %0b, actual %0b",
                             $time, want.vertex, want.last, m_tlast);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // driver: offers queued transactions, random gap after each one
    // ---------------------------------------------------------------
    int s_gap  = 0;
    int s_pace = 0;

    always @(negedge clk)
    begin : op_driver
        graph_op_t op;
        // hold the current transaction until it is taken
        if (!s_tvalid || s_xfer)
        begin
            if (s_gap > 0)
            begin
                s_gap    <= s_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (rst_n && pending_ops.size() > 0)
            begin
                op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= op.cmd;
                s_tdata  <= {{(S_TDATA_W-2*VERT_W-1){1'b0}}, op.edge_on, op.col, op.row};
                // pacing drifts between no gaps, short gaps and full gaps
                if ($urandom_range(0, 11) == 0)
                    s_pace <= $urandom_range(0, 2);
                s_gap <= draw_gap(s_pace);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // result sink: random stall after each result, plus a long hold-off
    // when the stimulus asks for one
    // ---------------------------------------------------------------
    int stall_order = 0;   // bumped by the stimulus to request a hold-off
    int stall_done  = 0;
    int stall_left  = 0;
    int m_wait      = 0;
    int m_pace      = 0;

    always @(negedge clk)
    begin : result_sink
        if (stall_order != stall_done)
        begin
            stall_left = LONG_HOLD;
            stall_done = stall_order;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (m_xfer)
        begin
            if ($urandom_range(0, 11) == 0)
                m_pace = $urandom_range(0, 2);
            m_wait = draw_gap(m_pace);
            if (m_wait > 0)
            begin
                m_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
        else if (m_wait > 0)
        begin
            m_wait--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_write(input int r, input int c, input bit e);
        graph_op_t op;
        op.cmd     = CMD_WRITE;
        op.row     = r[VERT_W-1:0];
        op.col     = c[VERT_W-1:0];
        op.edge_on = e;
        pending_ops.push_back(op);
    endtask

    task automatic queue_start();
        graph_op_t op;
        op.cmd     = CMD_START;
        op.row     = VERT_W'($urandom_range(0, NODES - 1));   // ignored on a start
        op.col     = VERT_W'($urandom_range(0, NODES - 1));
        op.edge_on = 1'($urandom_range(0, 1));
        pending_ops.push_back(op);
    endtask

    // waits until every transaction is sent and every visit is out, then lets a trailing walk scan finish
    task automatic wait_idle();
        int eff;
        while (pending_ops.size() != 0 || s_tvalid || visit_q.size() != 0)
            @(posedge clk);
        eff = (cfg_count > NODES) ? NODES : cfg_count;
        repeat (2 * eff * eff + 40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int count, input logic mode);
        write_reg(CFG_VERTEX_COUNT, count);
        write_reg(CFG_ORDER_MODE, mode);
    endtask

    // random matrix traffic, mostly inside the given span of vertices, with starts mixed in
    task automatic random_phase(input int count, input logic mode, input int items,
                                input int span);
        int n;
        int r;
        int c;
        wait_idle();
        set_config(count, mode);
        for (n = 0; n < items; n++)
        begin
            if ($urandom_range(0, 7) == 0 || n == items - 1)
                queue_start();
            else
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    r = $urandom_range(0, NODES - 1);
                    c = $urandom_range(0, NODES - 1);
                end
                else
                begin
                    r = $urandom_range(0, span - 1);
                    c = $urandom_range(0, span - 1);
                end
                queue_write(r, c, $urandom_range(0, 2) != 0);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: one vertex, preorder, empty matrix
        queue_start();
        wait_idle();

        // small directed graph, both orders
        set_config(6, MODE_PREORDER);
        queue_write(0, 2, 1'b1);
        queue_write(2, 1, 1'b1);
        queue_write(0, 1, 1'b1);
        queue_write(1, 3, 1'b1);
        queue_write(3, 3, 1'b1);     // self loop
        queue_write(4, 5, 1'b1);     // one-way edge, 5 has no way back
        queue_write(5, 63, 1'b1);    // edge to a vertex outside the count
        queue_write(63, 63, 1'b1);
        queue_write(0, 63, 1'b1);
        queue_write(63, 0, 1'b1);
        queue_write(2, 4, 1'b0);     // clearing an absent entry
        queue_write(0, 1, 1'b0);     // clearing a present entry
        queue_start();
        wait_idle();
        set_config(6, MODE_PUSH_MARK);
        queue_start();
        wait_idle();

        // zero vertices: no results at all
        set_config(0, MODE_PREORDER);
        queue_start();
        wait_idle();

        // count above the node limit, then exactly at it
        set_config(127, MODE_PUSH_MARK);
        queue_start();
        wait_idle();
        set_config(NODES, MODE_PREORDER);
        queue_start();
        wait_idle();

        // random phases across counts and orders
        random_phase(5, MODE_PREORDER, 30, 5);
        random_phase(8, MODE_PUSH_MARK, 30, 8);

        // long receiver hold-off with starts queued up front so the input backs up
        wait_idle();
        set_config(10, MODE_PREORDER);
        stall_order++;
        queue_start();
        queue_start();
        queue_start();
        random_phase(12, MODE_PUSH_MARK, 30, 12);

        random_phase(3, MODE_PUSH_MARK, 25, 3);
        random_phase(16, MODE_PUSH_MARK, 30, 16);
        random_phase(2, MODE_PREORDER, 20, 2);
        random_phase(127, MODE_PREORDER, 20, NODES);
        random_phase(1, MODE_PUSH_MARK, 10, 4);
        random_phase(10, MODE_PREORDER, 30, 10);
        wait_idle();

        $display("covered %0d input transactions with %0d walks and %0d register writes",
                 ops_accepted, walks_started, reg_writes);
        $display("checked %0d visited vertices, counts from zero past the node limit, both orders",
                 visits_checked);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #RUN_LIMIT;
        $display("%0t: timeout with %0d visits outstanding and %0d transactions unsent",
                 $time, visit_q.size(), pending_ops.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
